[design/lrc_timestamp_parser_assert.svh]
// assertion macros of the timestamp parser, used by lts_fsm
// no dependencies; taken in by `include where assertions are written
`ifndef LRC_TIMESTAMP_PARSER_ASSERT_SVH
`define LRC_TIMESTAMP_PARSER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timestamp parser check failed");

// next-cycle implication, disabled while in reset
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timestamp parser check failed");

`endif

[design/lts_pkg.sv]
// types, constants and helper functions of the lrc timestamp parser
// no dependencies; imported by every file of the block but the assertion header
package lts_pkg;

    // limits
    localparam int MAX_STAMPS_PER_LINE = 8;
    localparam int STAMP_CNT_W         = $clog2(MAX_STAMPS_PER_LINE + 1);
    localparam int BYTE_W              = 8;
    localparam int MS_W                = 30;
    localparam int SLOT_W              = 3;
    localparam int ACC_W               = 14;
    localparam int FRAC_W              = 10;
    localparam int FRAC_CNT_W          = 2;
    localparam logic [ACC_W-1:0]      ACC_MAX        = ACC_W'(9999);
    localparam logic [FRAC_CNT_W-1:0] FRAC_KEEP      = FRAC_CNT_W'(3);
    localparam logic [MS_W-1:0]       MS_PER_MIN     = MS_W'(60000);
    localparam logic [MS_W-1:0]       MS_PER_SEC     = MS_W'(1000);

    // characters
    localparam logic [BYTE_W-1:0] CHAR_OPEN    = 8'h5B;  // [
    localparam logic [BYTE_W-1:0] CHAR_CLOSE   = 8'h5D;  // ]
    localparam logic [BYTE_W-1:0] CHAR_COLON   = 8'h3A;  // :
    localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'h2E;  // .
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;  // \n
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;  // 0
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;  // 9

    // fraction digit counts
    localparam logic [FRAC_CNT_W-1:0] FRAC_NONE  = 2'd0;
    localparam logic [FRAC_CNT_W-1:0] FRAC_TENTH = 2'd1;
    localparam logic [FRAC_CNT_W-1:0] FRAC_HUND  = 2'd2;
    localparam logic [FRAC_CNT_W-1:0] FRAC_MILLI = 2'd3;

    // parser phases
    typedef enum logic [2:0] {
        PH_OPEN,
        PH_MIN_FIRST,
        PH_MIN,
        PH_SEC,
        PH_FRAC,
        PH_BODY
    } phase_t;

    // finished stamp handed from the parser to the converter
    typedef struct packed {
        logic [ACC_W-1:0]      minutes;
        logic [ACC_W-1:0]      seconds;
        logic [FRAC_W-1:0]     fraction;
        logic [FRAC_CNT_W-1:0] frac_digits;
        logic [SLOT_W-1:0]     slot;
    } stamp_rec_t;

    // append a decimal digit, saturating at ACC_MAX
    function automatic logic [ACC_W-1:0] sat_push(input logic [ACC_W-1:0] acc,
                                                  input logic [3:0] d);
        logic [ACC_W+3:0] v;
        v = (ACC_W+4)'(acc) * (ACC_W+4)'(10) + (ACC_W+4)'(d);
        sat_push = (v > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
    endfunction

endpackage

[design/lts_byte_if.sv]
// byte input channel of the lrc timestamp parser
// depends on lts_pkg
interface lts_byte_if
    import lts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

[design/lts_stamp_if.sv]
// stamp result channel of the lrc timestamp parser
// depends on lts_pkg
interface lts_stamp_if
    import lts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MS_W-1:0]   stamp_ms;
    logic [SLOT_W-1:0] stamp_slot;

    modport source (output valid, output stamp_ms, output stamp_slot, input ready);
    modport sink   (input valid, input stamp_ms, input stamp_slot, output ready);
endinterface

[design/lts_fsm.sv]
// character parser: phase machine, digit accumulators and stamp record register
// depends on lts_pkg and lrc_timestamp_parser_assert.svh
`include "lrc_timestamp_parser_assert.svh"

module lts_fsm
    import lts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] text_byte,
    output logic              rec_valid,
    input  logic              rec_ready,
    output stamp_rec_t        rec
);

    phase_t                  phase_reg, phase_next;
    logic [ACC_W-1:0]        minutes_acc_reg, minutes_acc_next;
    logic [ACC_W-1:0]        seconds_acc_reg, seconds_acc_next;
    logic [FRAC_W-1:0]       fraction_acc_reg, fraction_acc_next;
    logic [FRAC_CNT_W-1:0]   fraction_digits_reg, fraction_digits_next;
    logic [STAMP_CNT_W-1:0]  stamps_in_line_reg, stamps_in_line_next;
    logic                    rec_valid_reg;
    stamp_rec_t              rec_reg;

    logic                    accept;
    logic                    is_digit;
    logic                    is_newline;
    logic                    close_hit;
    logic                    line_full;
    logic [3:0]              digit_val;

    // character classes
    assign accept     = in_valid && in_ready;
    assign in_ready   = !rec_valid_reg || rec_ready;
    assign is_digit   = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    assign digit_val  = is_digit ? 4'(text_byte - CHAR_ZERO) : 4'd0;
    assign is_newline = (text_byte == CHAR_NEWLINE);
    assign close_hit  = !is_newline && (text_byte == CHAR_CLOSE)
                        && ((phase_reg == PH_SEC) || (phase_reg == PH_FRAC));
    assign line_full  = (stamps_in_line_reg >= STAMP_CNT_W'(MAX_STAMPS_PER_LINE - 1));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_newline)
        begin
            phase_next = PH_OPEN;
        end
        else
        begin
            unique case (phase_reg)
                PH_OPEN:
                    phase_next = (text_byte == CHAR_OPEN) ? PH_MIN_FIRST : PH_BODY;
                PH_MIN_FIRST:
                    phase_next = is_digit ? PH_MIN : PH_BODY;
                PH_MIN:
                    if (is_digit)
                        phase_next = PH_MIN;
                    else if (text_byte == CHAR_COLON)
                        phase_next = PH_SEC;
                    else
                        phase_next = PH_BODY;
                PH_SEC:
                    if (is_digit)
                        phase_next = PH_SEC;
                    else if ((text_byte == CHAR_DOT) || (text_byte == CHAR_COLON))
                        phase_next = PH_FRAC;
                    else if (close_hit)
                        phase_next = line_full ? PH_BODY : PH_OPEN;
                    else
                        phase_next = PH_BODY;
                PH_FRAC:
                    if (is_digit)
                        phase_next = PH_FRAC;
                    else if (close_hit)
                        phase_next = line_full ? PH_BODY : PH_OPEN;
                    else
                        phase_next = PH_BODY;
                default:
                    phase_next = PH_BODY;
            endcase
        end
    end

    // accumulator and stamp count updates
    always_comb
    begin
        minutes_acc_next     = minutes_acc_reg;
        seconds_acc_next     = seconds_acc_reg;
        fraction_acc_next    = fraction_acc_reg;
        fraction_digits_next = fraction_digits_reg;
        stamps_in_line_next  = stamps_in_line_reg;
        if (is_newline || close_hit || ((phase_reg == PH_OPEN) && (text_byte == CHAR_OPEN)))
        begin
            minutes_acc_next     = '0;
            seconds_acc_next     = '0;
            fraction_acc_next    = '0;
            fraction_digits_next = FRAC_NONE;
            if (is_newline)
                stamps_in_line_next = '0;
            else if (close_hit)
                stamps_in_line_next = stamps_in_line_reg + STAMP_CNT_W'(1);
        end
        else if (is_digit)
        begin
            unique case (phase_reg) inside
                PH_MIN_FIRST, PH_MIN:
                    minutes_acc_next = sat_push(minutes_acc_reg, digit_val);
                PH_SEC:
                    seconds_acc_next = sat_push(seconds_acc_reg, digit_val);
                PH_FRAC:
                    if (fraction_digits_reg < FRAC_KEEP)
                    begin
                        fraction_acc_next    = FRAC_W'(fraction_acc_reg * FRAC_W'(10)
                                                       + FRAC_W'(digit_val));
                        fraction_digits_next = fraction_digits_reg + FRAC_CNT_W'(1);
                    end
                default:
                    ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_OPEN;
            minutes_acc_reg     <= '0;
            seconds_acc_reg     <= '0;
            fraction_acc_reg    <= '0;
            fraction_digits_reg <= FRAC_NONE;
            stamps_in_line_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg           <= phase_next;
            minutes_acc_reg     <= minutes_acc_next;
            seconds_acc_reg     <= seconds_acc_next;
            fraction_acc_reg    <= fraction_acc_next;
            fraction_digits_reg <= fraction_digits_next;
            stamps_in_line_reg  <= stamps_in_line_next;
        end
    end

    // finished stamp record, held until the converter takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_valid_reg <= 1'b0;
        else if (accept)
            rec_valid_reg <= close_hit;
        else if (rec_ready)
            rec_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && close_hit)
        begin
            rec_reg.minutes     <= minutes_acc_reg;
            rec_reg.seconds     <= seconds_acc_reg;
            rec_reg.fraction    <= fraction_acc_reg;
            rec_reg.frac_digits <= fraction_digits_reg;
            rec_reg.slot        <= SLOT_W'(stamps_in_line_reg);
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    // checks
    `LTS_ASSERT_IMPL(a_open_clear, clk, rst_n, (phase_reg == PH_OPEN),
        ((minutes_acc_reg == '0) && (seconds_acc_reg == '0) && (fraction_acc_reg == '0)))
    `LTS_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
        (stamps_in_line_reg <= STAMP_CNT_W'(MAX_STAMPS_PER_LINE)))
    `LTS_ASSERT_NEXT(a_newline_restart, clk, rst_n, (accept && is_newline),
        ((phase_reg == PH_OPEN) && (stamps_in_line_reg == '0) && !rec_valid_reg))

endmodule

[design/lts_conv.sv]
// millisecond conversion of a finished stamp into the output register
// depends on lts_pkg
module lts_conv
    import lts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_valid,
    output logic              rec_ready,
    input  stamp_rec_t        rec,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MS_W-1:0]   stamp_ms,
    output logic [SLOT_W-1:0] stamp_slot
);

    logic                out_valid_reg;
    logic [MS_W-1:0]     stamp_ms_reg, stamp_ms_next;
    logic [SLOT_W-1:0]   stamp_slot_reg;
    logic [FRAC_W-1:0]   frac_ms;

    assign rec_ready = !out_valid_reg || out_ready;

    // pad the kept fraction digits to milliseconds
    always_comb
    begin
        unique case (rec.frac_digits)
            FRAC_NONE:  frac_ms = '0;
            FRAC_TENTH: frac_ms = FRAC_W'(rec.fraction * FRAC_W'(100));
            FRAC_HUND:  frac_ms = FRAC_W'(rec.fraction * FRAC_W'(10));
            FRAC_MILLI: frac_ms = rec.fraction;
            default:    frac_ms = '0;
        endcase
    end

    // minutes and seconds by constant multiplies, then one sum
    assign stamp_ms_next = MS_W'(rec.minutes) * MS_PER_MIN
                         + MS_W'(rec.seconds) * MS_PER_SEC
                         + MS_W'(frac_ms);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rec_ready)
            out_valid_reg <= rec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rec_ready && rec_valid)
        begin
            stamp_ms_reg   <= stamp_ms_next;
            stamp_slot_reg <= rec.slot;
        end
    end

    assign out_valid  = out_valid_reg;
    assign stamp_ms   = stamp_ms_reg;
    assign stamp_slot = stamp_slot_reg;

endmodule

[design/lrc_timestamp_parser.sv]
// top level of the lrc lyric timestamp parser
// depends on lts_pkg, lts_byte_if, lts_stamp_if, lts_fsm and lts_conv
//
// Usage:
//   byte_in carries lyric text, one ASCII byte per transfer. stamp_out gives
//   one transfer per complete [mm:ss], [mm:ss.f..] or [mm:ss:f..] stamp at
//   the start of a line: stamp_ms in milliseconds and stamp_slot, its place
//   among the line's stamps. Bytes that are not part of a stamp give nothing.
//   Throughput: one byte per cycle, sustained, with stamp_out ready.
//   Path: the transfer of the closing bracket loads the record register,
//   which then loads the output register once that is free; stamp_out.valid
//   rises when the output register holds the stamp.
//   Stalls: when stamp_out is held off, the output register and the stamp
//   record register fill; byte_in.ready then drops and rises again in the
//   cycle the receiver takes the waiting stamp. Nothing is dropped.
//   Reset: rst_n is asynchronous, active low; the parser returns to the
//   start of a line with cleared accumulators and no stamp pending.
module lrc_timestamp_parser
    import lts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lts_byte_if.sink           byte_in,
    lts_stamp_if.source        stamp_out
);

    logic       rec_valid;
    logic       rec_ready;
    stamp_rec_t rec;

    // character parser
    lts_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_in.valid),
        .in_ready  (byte_in.ready),
        .text_byte (byte_in.text_byte),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    // millisecond conversion and output register
    lts_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec        (rec),
        .out_valid  (stamp_out.valid),
        .out_ready  (stamp_out.ready),
        .stamp_ms   (stamp_out.stamp_ms),
        .stamp_slot (stamp_out.stamp_slot)
    );

endmodule
